[hdl/accumulator_alu_with_flags_defines.svh]
// Assertion helpers for the accumulator ALU.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ACC_ALU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("accumulator ALU assertion failed");

// Next-cycle implication.
`define ACC_ALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("accumulator ALU assertion failed");

`endif

[hdl/acc_alu_pkg.sv]
package acc_alu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned OpW   = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADC = 4'd0,
    OP_SBC = 4'd1,
    OP_AND = 4'd2,
    OP_ORA = 4'd3,
    OP_EOR = 4'd4,
    OP_ASL = 4'd5,
    OP_LSR = 4'd6,
    OP_ROL = 4'd7,
    OP_ROR = 4'd8,
    OP_INX = 4'd9,
    OP_DEX = 4'd10,
    OP_INY = 4'd11,
    OP_DEY = 4'd12,
    OP_TAX = 4'd13,
    OP_TXA = 4'd14,
    OP_LDA = 4'd15
  } op_t;

  // Architectural registers and flags.
  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic             c;
    logic             z;
    logic             n;
  } regs_t;

  // Pipeline handshake between the stages.
  typedef struct packed {
    logic fire;     // input register word executes this cycle
  } pipe_ctrl_t;

endpackage

[hdl/acc_alu_in_if.sv]
interface acc_alu_in_if;
  logic                             valid;
  logic                             ready;
  logic [acc_alu_pkg::OpW-1:0]      action;
  logic [acc_alu_pkg::DataW-1:0]    operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

[hdl/acc_alu_out_if.sv]
interface acc_alu_out_if;
  logic                             valid;
  logic                             ready;
  logic [acc_alu_pkg::DataW-1:0]    acc_out;
  logic [acc_alu_pkg::DataW-1:0]    x_out;
  logic [acc_alu_pkg::DataW-1:0]    y_out;
  logic                             carry_out;
  logic                             zero_out;
  logic                             negative_out;

  modport source (output valid, acc_out, x_out, y_out, carry_out, zero_out, negative_out,
                  input ready);
  modport sink   (input valid, acc_out, x_out, y_out, carry_out, zero_out, negative_out,
                  output ready);
endinterface

[hdl/acc_alu_in_stage.sv]
module acc_alu_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  acc_alu_in_if.sink                    req,
  input  logic                          advance,
  output acc_alu_pkg::pipe_ctrl_t       ctrl,
  output logic [acc_alu_pkg::OpW-1:0]   action,
  output logic [acc_alu_pkg::DataW-1:0] operand
);

  logic valid;

  assign req.ready    = !valid || advance;
  assign ctrl.fire    = valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      action  <= req.action;
      operand <= req.operand;
    end
  end

endmodule

[hdl/acc_alu_exec.sv]
module acc_alu_exec (
  input  logic                          clk,
  input  logic                          rst,
  input  acc_alu_pkg::pipe_ctrl_t       ctrl,
  input  logic [acc_alu_pkg::OpW-1:0]   action,
  input  logic [acc_alu_pkg::DataW-1:0] operand,
  output acc_alu_pkg::regs_t            regs,
  output acc_alu_pkg::regs_t            regs_next
);

  logic [acc_alu_pkg::DataW:0]   sum;
  logic [acc_alu_pkg::DataW-1:0] addend;
  logic [acc_alu_pkg::DataW-1:0] res;

  // sbc is a + ~m + c; carry out of bit 7 means no borrow
  assign addend = (acc_alu_pkg::op_t'(action) == acc_alu_pkg::OP_SBC) ? ~operand : operand;
  assign sum    = {1'b0, regs.a} + {1'b0, addend} + {{acc_alu_pkg::DataW{1'b0}}, regs.c};

  always_comb begin
    regs_next = regs;
    res       = regs.a;
    case (acc_alu_pkg::op_t'(action))
      acc_alu_pkg::OP_ADC,
      acc_alu_pkg::OP_SBC: begin
        res         = sum[acc_alu_pkg::DataW-1:0];
        regs_next.a = res;
        regs_next.c = sum[acc_alu_pkg::DataW];
      end
      acc_alu_pkg::OP_AND: begin
        res         = regs.a & operand;
        regs_next.a = res;
      end
      acc_alu_pkg::OP_ORA: begin
        res         = regs.a | operand;
        regs_next.a = res;
      end
      acc_alu_pkg::OP_EOR: begin
        res         = regs.a ^ operand;
        regs_next.a = res;
      end
      acc_alu_pkg::OP_ASL: begin
        res         = {regs.a[acc_alu_pkg::DataW-2:0], 1'b0};
        regs_next.a = res;
        regs_next.c = regs.a[acc_alu_pkg::DataW-1];
      end
      acc_alu_pkg::OP_LSR: begin
        res         = {1'b0, regs.a[acc_alu_pkg::DataW-1:1]};
        regs_next.a = res;
        regs_next.c = regs.a[0];
      end
      acc_alu_pkg::OP_ROL: begin
        res         = {regs.a[acc_alu_pkg::DataW-2:0], regs.c};
        regs_next.a = res;
        regs_next.c = regs.a[acc_alu_pkg::DataW-1];
      end
      acc_alu_pkg::OP_ROR: begin
        res         = {regs.c, regs.a[acc_alu_pkg::DataW-1:1]};
        regs_next.a = res;
        regs_next.c = regs.a[0];
      end
      acc_alu_pkg::OP_INX: begin
        res         = regs.x + 8'd1;
        regs_next.x = res;
      end
      acc_alu_pkg::OP_DEX: begin
        res         = regs.x - 8'd1;
        regs_next.x = res;
      end
      acc_alu_pkg::OP_INY: begin
        res         = regs.y + 8'd1;
        regs_next.y = res;
      end
      acc_alu_pkg::OP_DEY: begin
        res         = regs.y - 8'd1;
        regs_next.y = res;
      end
      acc_alu_pkg::OP_TAX: begin
        res         = regs.a;
        regs_next.x = res;
      end
      acc_alu_pkg::OP_TXA: begin
        res         = regs.x;
        regs_next.a = res;
      end
      default: begin
        res         = operand;
        regs_next.a = res;
      end
    endcase
    regs_next.z = (res == '0);
    regs_next.n = res[acc_alu_pkg::DataW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (ctrl.fire) begin
      regs <= regs_next;
    end
  end

endmodule

[hdl/acc_alu_out_stage.sv]
module acc_alu_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_alu_pkg::pipe_ctrl_t ctrl,
  input  acc_alu_pkg::regs_t      result,
  output logic                    advance,
  acc_alu_out_if.source           rsp
);

  logic               valid;
  acc_alu_pkg::regs_t word;

  assign advance = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.fire) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      word <= result;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.acc_out      = word.a;
  assign rsp.x_out        = word.x;
  assign rsp.y_out        = word.y;
  assign rsp.carry_out    = word.c;
  assign rsp.zero_out     = word.z;
  assign rsp.negative_out = word.n;

endmodule

[hdl/accumulator_alu_with_flags.sv]
// An accepted word waits in the input register and its result is captured in the result
// register. Throughput: one word per cycle while rsp.ready is high; the 8-bit ALU with
// the register file feedback sits between the input register and the result register.
// Reset (rst, synchronous, active high): A, X, Y and all flags clear to zero,
// and both pipeline registers empty.
`include "accumulator_alu_with_flags_defines.svh"

module accumulator_alu_with_flags (
  input  logic          clk,
  input  logic          rst,
  acc_alu_in_if.sink    req,
  acc_alu_out_if.source rsp
);

  acc_alu_pkg::pipe_ctrl_t       ctrl;
  logic                          advance;
  logic [acc_alu_pkg::OpW-1:0]   action;
  logic [acc_alu_pkg::DataW-1:0] operand;
  acc_alu_pkg::regs_t            regs;
  acc_alu_pkg::regs_t            regs_next;

  acc_alu_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .ctrl    (ctrl),
    .action  (action),
    .operand (operand)
  );

  acc_alu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .action    (action),
    .operand   (operand),
    .regs      (regs),
    .regs_next (regs_next)
  );

  acc_alu_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .result  (regs_next),
    .advance (advance),
    .rsp     (rsp)
  );

  // a shown result always mirrors the live register file
  `ACC_ALU_ASSERT_NOW(a_rsp_acc_x, rsp.valid, rsp.acc_out == regs.a && rsp.x_out == regs.x)
  `ACC_ALU_ASSERT_NOW(a_rsp_y_carry, rsp.valid, rsp.y_out == regs.y && rsp.carry_out == regs.c)
  `ACC_ALU_ASSERT_NOW(a_rsp_flags, rsp.valid, rsp.zero_out == regs.z && rsp.negative_out == regs.n)
  `ACC_ALU_ASSERT_NEXT(a_fire_shows_result, ctrl.fire, rsp.valid)
  `ACC_ALU_ASSERT_NEXT(a_stall_holds_regs, !ctrl.fire, $stable(regs))
  `ACC_ALU_ASSERT_NOW(a_full_blocks_input, rsp.valid && !rsp.ready && !req.ready, !ctrl.fire)

endmodule
